FILE: hw/rtl/b32e_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b32e_pkg
// shared types, constants and codes of the bech32 / bech32m string encoder
// ----------------------------------------------------------------------------
package b32e_pkg;

    // sizing
    localparam int MAX_PREFIX_LEN = 83;
    localparam int MAX_TOTAL_LEN  = 90;
    localparam int PIDX_W = $clog2(MAX_PREFIX_LEN);
    localparam int PCNT_W = $clog2(MAX_PREFIX_LEN + 1);
    localparam int TCNT_W = $clog2(MAX_TOTAL_LEN + 1);
    localparam int SUM_W  = ((PCNT_W > TCNT_W) ? PCNT_W : TCNT_W) + 1;

    // bch polymod
    localparam int CS_W = 30;
    localparam logic [CS_W-1:0] GEN_POLY [5] = '{
        30'h3B6A57B2, 30'h26508E6D, 30'h1EA119FA, 30'h3D4233DD, 30'h2A1462B3
    };
    localparam logic [CS_W-1:0] CONST_BECH32  = 30'h00000001;
    localparam logic [CS_W-1:0] CONST_BECH32M = 30'h2BC830A3;
    localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
    localparam logic [7:0] SEP_CHAR = 8'h31;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SYMBOL = 2'd1;
    localparam logic [1:0] ST_PREFIX = 2'd2;
    localparam logic [1:0] ST_LONG   = 2'd3;

    // item kinds
    localparam logic KIND_PREFIX = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_DATA   = 2'd1,
        PH_DROP   = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_DISPATCH,
        CS_ERROR,
        CS_ECHO,
        CS_SEP_ZERO,
        CS_SEP_REPLAY,
        CS_SEP_EMIT,
        CS_DATA,
        CS_FIN_FEED,
        CS_FIN_EMIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        FD_ZERO,
        FD_HIGH,
        FD_STORE,
        FD_DATA
    } feed_sel_t;

    typedef enum logic [2:0] {
        EM_ERROR,
        EM_ECHO,
        EM_SEP,
        EM_DATA,
        EM_CSUM
    } emit_sel_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] status;
        logic       run_last;
        logic       string_end;
    } out_item_t;

    typedef struct packed {
        logic      latch_item;
        logic      feed_en;
        feed_sel_t feed_sel;
        logic      feed_xor;
        logic      cs_shift;
        logic      store_wr;
        logic      rd_start;
        logic      rd_next;
        logic      emit_en;
        emit_sel_t emit_sel;
        logic      prefix_inc;
        logic      total_inc;
        logic      set_data;
        logic      set_drop;
        logic      restart;
        logic      cnt_inc;
        logic      cnt_clr;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       kind;
        logic       last;
        logic [1:0] err;
        logic       drop;
        logic       prefix_phase;
        logic       slot_free;
        logic       replay_done;
        logic       cnt_last;
    } ctrl_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/b32e_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b32e_ctrl
// sequencer: walks one transaction through checks, emits and polymod feeds
// ----------------------------------------------------------------------------
module b32e_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire b32e_pkg::ctrl_sts_t sts,
    output b32e_pkg::ctrl_cmd_t    cmd
);
    import b32e_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (s_valid) state_next = CS_DISPATCH;
            end
            CS_DISPATCH: begin
                if (sts.drop) state_next = CS_IDLE;
                else if (sts.err != ST_OK) state_next = CS_ERROR;
                else if (sts.kind == KIND_PREFIX) state_next = CS_ECHO;
                else if (sts.prefix_phase) state_next = CS_SEP_ZERO;
                else state_next = CS_DATA;
            end
            CS_ERROR: begin
                if (sts.slot_free) state_next = CS_IDLE;
            end
            CS_ECHO: begin
                if (sts.slot_free) state_next = sts.last ? CS_SEP_ZERO : CS_IDLE;
            end
            CS_SEP_ZERO: begin
                state_next = CS_SEP_REPLAY;
            end
            CS_SEP_REPLAY: begin
                if (sts.replay_done) state_next = CS_SEP_EMIT;
            end
            CS_SEP_EMIT: begin
                if (sts.slot_free) begin
                    state_next = (sts.kind == KIND_DATA) ? CS_DATA : CS_FIN_FEED;
                end
            end
            CS_DATA: begin
                if (sts.slot_free) state_next = sts.last ? CS_FIN_FEED : CS_IDLE;
            end
            CS_FIN_FEED: begin
                if (sts.cnt_last) state_next = CS_FIN_EMIT;
            end
            CS_FIN_EMIT: begin
                if (sts.slot_free && sts.cnt_last) state_next = CS_IDLE;
            end
            default: state_next = CS_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.feed_sel = FD_ZERO;
        cmd.emit_sel = EM_ERROR;
        s_ready = 1'b0;
        unique case (state_reg)
            CS_IDLE: begin
                s_ready = 1'b1;
                cmd.latch_item = s_valid;
            end
            CS_DISPATCH: begin
                cmd.restart = sts.drop && sts.last;
            end
            CS_ERROR: begin
                if (sts.slot_free) begin
                    cmd.emit_en  = 1'b1;
                    cmd.emit_sel = EM_ERROR;
                    cmd.restart  = sts.last;
                    cmd.set_drop = !sts.last;
                end
            end
            CS_ECHO: begin
                if (sts.slot_free) begin
                    cmd.emit_en    = 1'b1;
                    cmd.emit_sel   = EM_ECHO;
                    cmd.feed_en    = 1'b1;
                    cmd.feed_sel   = FD_HIGH;
                    cmd.store_wr   = 1'b1;
                    cmd.prefix_inc = 1'b1;
                    cmd.total_inc  = 1'b1;
                end
            end
            CS_SEP_ZERO: begin
                cmd.feed_en  = 1'b1;
                cmd.feed_sel = FD_ZERO;
                cmd.rd_start = 1'b1;
            end
            CS_SEP_REPLAY: begin
                cmd.feed_en  = 1'b1;
                cmd.feed_sel = FD_STORE;
                cmd.rd_next  = !sts.replay_done;
            end
            CS_SEP_EMIT: begin
                if (sts.slot_free) begin
                    cmd.emit_en   = 1'b1;
                    cmd.emit_sel  = EM_SEP;
                    cmd.total_inc = 1'b1;
                    cmd.set_data  = 1'b1;
                end
            end
            CS_DATA: begin
                if (sts.slot_free) begin
                    cmd.emit_en   = 1'b1;
                    cmd.emit_sel  = EM_DATA;
                    cmd.feed_en   = 1'b1;
                    cmd.feed_sel  = FD_DATA;
                    cmd.total_inc = 1'b1;
                end
            end
            CS_FIN_FEED: begin
                cmd.feed_en  = 1'b1;
                cmd.feed_sel = FD_ZERO;
                cmd.feed_xor = sts.cnt_last;
                cmd.cnt_inc  = !sts.cnt_last;
                cmd.cnt_clr  = sts.cnt_last;
            end
            CS_FIN_EMIT: begin
                if (sts.slot_free) begin
                    cmd.emit_en  = 1'b1;
                    cmd.emit_sel = EM_CSUM;
                    cmd.cs_shift = 1'b1;
                    cmd.cnt_inc  = !sts.cnt_last;
                    cmd.cnt_clr  = sts.cnt_last;
                    cmd.restart  = sts.cnt_last;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // feeds that run without the output slot never wait on it
    a_replay_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CS_SEP_REPLAY && !sts.replay_done) |=> (state_reg == CS_SEP_REPLAY))
        else $error("replay left early");
    a_echo_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CS_ECHO && sts.slot_free && !sts.last) |=> (state_reg == CS_IDLE))
        else $error("echo did not return to idle");
    a_fin_after_feed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == CS_FIN_FEED && sts.cnt_last) |=> (state_reg == CS_FIN_EMIT))
        else $error("checksum feed did not hand over to emit");

endmodule
`default_nettype wire

FILE: hw/rtl/b32e_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b32e_datapath
// item register, checks, polymod, prefix store, counters and result register
// ----------------------------------------------------------------------------
module b32e_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_wdata,
    input  wire b32e_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output b32e_pkg::out_item_t      m_data,
    input  wire b32e_pkg::ctrl_cmd_t cmd,
    output b32e_pkg::ctrl_sts_t      sts
);
    import b32e_pkg::*;

    function automatic logic [CS_W-1:0] polymod_step(input logic [CS_W-1:0] c,
                                                     input logic [4:0] sym);
        logic [CS_W-1:0] n;
        n = {c[CS_W-6:0], 5'b0} ^ {{(CS_W-5){1'b0}}, sym};
        for (int j = 0; j < 5; j++) begin
            if (c[CS_W-5+j]) n = n ^ GEN_POLY[j];
        end
        return n;
    endfunction

    function automatic logic [7:0] charset_lookup(input logic [4:0] idx);
        return CHARSET[8*(31-int'(idx)) +: 8];
    endfunction

    localparam logic [SUM_W-1:0] TOTAL_LIMIT = SUM_W'(MAX_TOTAL_LEN);
    localparam logic [SUM_W-1:0] PREFIX_LIMIT = SUM_W'(MAX_PREFIX_LEN);

    logic              variant_reg;
    in_item_t          item_reg;
    logic [CS_W-1:0]   checksum_reg;
    logic [CS_W-1:0]   checksum_next;
    logic [PCNT_W-1:0] prefix_count_reg;
    logic [TCNT_W-1:0] total_count_reg;
    phase_t            phase_reg;
    logic [PIDX_W-1:0] idx_reg;
    logic [PIDX_W-1:0] rd_addr;
    logic [4:0]        rd_data_reg;
    logic [4:0]        prefix_mem [MAX_PREFIX_LEN];
    logic [2:0]        cnt_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;
    out_item_t         emit_item;
    logic [4:0]        feed_sym;
    logic [1:0]        err;
    logic [7:0]        v;
    logic [SUM_W-1:0]  prefix_sum;
    logic [SUM_W-1:0]  total_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            variant_reg <= 1'b0;
        end else if (cfg_valid) begin
            variant_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_item) item_reg <= s_data;
    end

    // checks: a prefix byte for order, bad prefix, too long; a data symbol for empty prefix, bad symbol, too long
    assign v = item_reg.value;
    assign prefix_sum = SUM_W'(prefix_count_reg) + SUM_W'(8);
    assign total_sum  = SUM_W'(total_count_reg) + SUM_W'(phase_reg == PH_PREFIX)
                      + SUM_W'(7);

    always_comb begin
        err = ST_OK;
        if (item_reg.kind == KIND_PREFIX) begin
            if (phase_reg != PH_PREFIX) begin
                err = ST_SYMBOL;
            end else if (v < 8'd33 || v > 8'd126 || (v >= 8'h41 && v <= 8'h5A) ||
                         SUM_W'(prefix_count_reg) >= PREFIX_LIMIT) begin
                err = ST_PREFIX;
            end else if (prefix_sum > TOTAL_LIMIT) begin
                err = ST_LONG;
            end
        end else begin
            if (phase_reg == PH_PREFIX && prefix_count_reg == '0) begin
                err = ST_PREFIX;
            end else if (v > 8'd31) begin
                err = ST_SYMBOL;
            end else if (total_sum > TOTAL_LIMIT) begin
                err = ST_LONG;
            end
        end
    end

    // polymod
    always_comb begin
        case (cmd.feed_sel)
            FD_HIGH:  feed_sym = {2'b00, v[7:5]};
            FD_STORE: feed_sym = rd_data_reg;
            FD_DATA:  feed_sym = v[4:0];
            default:  feed_sym = 5'd0;
        endcase
    end

    always_comb begin
        checksum_next = checksum_reg;
        if (cmd.restart) begin
            checksum_next = CS_W'(1);
        end else if (cmd.feed_en) begin
            checksum_next = polymod_step(checksum_reg, feed_sym);
            if (cmd.feed_xor) begin
                checksum_next = checksum_next ^ (variant_reg ? CONST_BECH32M : CONST_BECH32);
            end
        end else if (cmd.cs_shift) begin
            checksum_next = {checksum_reg[CS_W-6:0], 5'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            checksum_reg <= CS_W'(1);
        end else begin
            checksum_reg <= checksum_next;
        end
    end

    // counters and phase
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            prefix_count_reg <= '0;
            total_count_reg  <= '0;
            phase_reg        <= PH_PREFIX;
        end else begin
            if (cmd.prefix_inc) prefix_count_reg <= prefix_count_reg + PCNT_W'(1);
            if (cmd.total_inc) total_count_reg <= total_count_reg + TCNT_W'(1);
            if (cmd.set_data) phase_reg <= PH_DATA;
            else if (cmd.set_drop) phase_reg <= PH_DROP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + 3'd1;
        end
    end

    // prefix low-bit store, replayed at the separator
    assign rd_addr = cmd.rd_start ? '0 : (idx_reg + PIDX_W'(1));

    always_ff @(posedge aclk) begin
        if (cmd.store_wr) prefix_mem[prefix_count_reg[PIDX_W-1:0]] <= v[4:0];
        if (cmd.rd_start || cmd.rd_next) rd_data_reg <= prefix_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_start) idx_reg <= '0;
        else if (cmd.rd_next) idx_reg <= idx_reg + PIDX_W'(1);
    end

    // result register
    always_comb begin
        emit_item = '0;
        unique case (cmd.emit_sel)
            EM_ERROR: begin
                emit_item.status     = err;
                emit_item.run_last   = 1'b1;
                emit_item.string_end = 1'b1;
            end
            EM_ECHO: begin
                emit_item.out_char = v;
                emit_item.run_last = !item_reg.last;
            end
            EM_SEP: begin
                emit_item.out_char = SEP_CHAR;
            end
            EM_DATA: begin
                emit_item.out_char = charset_lookup(v[4:0]);
                emit_item.run_last = !item_reg.last;
            end
            EM_CSUM: begin
                emit_item.out_char   = charset_lookup(checksum_reg[CS_W-1:CS_W-5]);
                emit_item.run_last   = (cnt_reg == 3'd5);
                emit_item.string_end = (cnt_reg == 3'd5);
            end
            default: emit_item = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_en) m_data_reg <= emit_item;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.kind         = item_reg.kind;
    assign sts.last         = item_reg.last;
    assign sts.err          = err;
    assign sts.drop         = (phase_reg == PH_DROP);
    assign sts.prefix_phase = (phase_reg == PH_PREFIX);
    assign sts.slot_free    = !m_valid_reg || m_ready;
    assign sts.replay_done  = (PCNT_W'(idx_reg) + PCNT_W'(1)) == prefix_count_reg;
    assign sts.cnt_last     = (cnt_reg == 3'd5);

    a_emit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_en |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before taken");
    a_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        TCNT_W'(prefix_count_reg) <= total_count_reg)
        else $error("total count below prefix count");
    a_data_has_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (prefix_count_reg != '0))
        else $error("data phase with empty prefix");
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.restart |=> (checksum_reg == CS_W'(1) && total_count_reg == '0))
        else $error("restart did not clear state");

endmodule
`default_nettype wire

FILE: hw/rtl/bech32_string_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bech32_string_encoder - streamed bech32 / bech32m string encoder
// per item: accept, check, emit; the emit waits for a free output slot, then the result is registered
// the separator: a zero feed, then the P prefix bytes replayed (one stored byte per cycle), then the separator char
// the end of a string adds six polymod feeds, then six checksum chars
// synchronous active-low reset: idle, checksum 1, counts zero, variant bech32
// ----------------------------------------------------------------------------
module bech32_string_encoder (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration: checksum variant
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_wdata,
    // input items
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire b32e_pkg::in_item_t s_data,
    // result items
    output logic                    m_valid,
    input  wire logic               m_ready,
    output b32e_pkg::out_item_t     m_data
);
    import b32e_pkg::*;

    // one transaction in flight at a time; the sequencer returns to idle after
    // its last result is placed in the output register, so the next item is
    // taken while that result still waits for the sink
    // throughput: one polymod feed per cycle through a single step unit (a feed that
    // emits waits for a free output slot), and one prefix-store read per cycle during the separator replay

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // sequencer: checks dispatch, emit order, replay and checksum loops
    b32e_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: item register, polymod, prefix store and result register
    b32e_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire
